FILE: rtl/core/tpgc_pkg.sv
package tpgc_pkg;

    // Fixed field widths.
    localparam int unsigned TIME_BITS      = 31;
    localparam int unsigned STAMP_BITS     = 32;
    localparam int unsigned ELAPSED_BITS   = 16;
    localparam int unsigned BASE_BITS      = 16;
    localparam int unsigned INC_BITS       = 12;
    localparam int unsigned BASE_MS_BITS   = 26;
    localparam int unsigned INC_MS_BITS    = 22;
    localparam int unsigned COUNT_OUT_BITS = 16;
    localparam int unsigned CFG_IDX_BITS   = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;

    localparam logic [TIME_BITS-1:0]     TIME_MAX       = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0]     WARN_MS        = TIME_BITS'(10000);
    localparam logic [9:0]               MS_PER_S       = 10'd1000;
    localparam logic [BASE_BITS-1:0]     BASE_RESET     = BASE_BITS'(300);
    localparam logic [TIME_BITS-1:0]     TIME_RESET     = TIME_BITS'(300000);

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_PRESS    = 2'd1,
        CMD_PAUSE    = 2'd2,
        CMD_NEW_GAME = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_PAUSE = 2'd2,
        PH_FLAG  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_UNTIMED   = 2'd0,
        MODE_INCREMENT = 2'd1,
        MODE_DELAY     = 2'd2,
        MODE_PLAIN     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ALERT_NONE = 2'd0,
        ALERT_FLAG = 2'd1,
        ALERT_WARN = 2'd2
    } t_alert;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TIMING_MODE = 2'd0,
        CFG_BASE_SEC    = 2'd1,
        CFG_INC_SEC     = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                      alert;
        logic [1:0]                alert_kind;
        logic [1:0]                run_state;
        logic                      side_to_move;
        logic [TIME_BITS-1:0]      white_left_ms;
        logic [TIME_BITS-1:0]      black_left_ms;
        logic                      flagged_side;
        logic [COUNT_OUT_BITS-1:0] white_move_count;
        logic [COUNT_OUT_BITS-1:0] black_move_count;
    } t_result;

endpackage

FILE: rtl/core/tpgc_cmd_if.sv
interface tpgc_cmd_if;
    import tpgc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic                    side;
    logic [STAMP_BITS-1:0]   now_ms;
    logic [ELAPSED_BITS-1:0] elapsed_ms;

    modport source (output valid, command, side, now_ms, elapsed_ms, input ready);
    modport sink   (input valid, command, side, now_ms, elapsed_ms, output ready);
endinterface

FILE: rtl/core/tpgc_res_if.sv
interface tpgc_res_if;
    import tpgc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      alert;
    logic [1:0]                alert_kind;
    logic [1:0]                run_state;
    logic                      side_to_move;
    logic [TIME_BITS-1:0]      white_left_ms;
    logic [TIME_BITS-1:0]      black_left_ms;
    logic                      flagged_side;
    logic [COUNT_OUT_BITS-1:0] white_move_count;
    logic [COUNT_OUT_BITS-1:0] black_move_count;

    modport source (output valid, alert, alert_kind, run_state, side_to_move,
                    white_left_ms, black_left_ms, flagged_side,
                    white_move_count, black_move_count, input ready);
    modport sink   (input valid, alert, alert_kind, run_state, side_to_move,
                    white_left_ms, black_left_ms, flagged_side,
                    white_move_count, black_move_count, output ready);
endinterface

FILE: rtl/core/two_player_game_clock.sv
// Each taken command's result is registered, in the skid register while a result still waits.
// Throughput: one command per cycle when ready; the update is a few adds and compares deep.
// A two-entry output stage (result register plus skid register) keeps input taking
// commands while one result waits; input stalls only when both entries are full.
// Reset (synchronous, active low) restores the default registers and a fresh game.
module two_player_game_clock #(
    parameter int unsigned MOVE_COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpgc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [tpgc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    tpgc_cmd_if.sink                      i_cmd,
    tpgc_res_if.source                    o_res
);
    import tpgc_pkg::*;

    // Configuration registers.
    t_mode                  r_mode;
    logic [BASE_BITS-1:0]   r_base_sec;
    logic [INC_BITS-1:0]    r_inc_sec;

    // Game state.
    t_phase                     r_phase,      n_phase;
    logic                       r_mover,      n_mover;
    logic [TIME_BITS-1:0]       r_time_left [2];
    logic [TIME_BITS-1:0]       n_time_left [2];
    logic [MOVE_COUNT_BITS-1:0] r_tally [2];
    logic [MOVE_COUNT_BITS-1:0] n_tally [2];
    logic [1:0]                 r_warned,     n_warned;
    logic [STAMP_BITS-1:0]      r_move_start, n_move_start;
    logic                       r_loser,      n_loser;
    t_alert                     n_kind;

    // Output stage.
    t_result r_out, r_skid, n_result;
    logic    r_out_v, r_skid_v;

    // Decoded command and shared arithmetic.
    t_cmd                   cmd;
    logic                   in_fire, out_fire;
    logic [BASE_MS_BITS-1:0] base_ms;
    logic [INC_MS_BITS-1:0]  inc_ms;
    logic [TIME_BITS-1:0]   mover_left, tick_left, press_left, base_left;
    logic                   tick_active, tick_flag, tick_warn, press_move;
    logic [STAMP_BITS-1:0]  used_ms;
    logic [INC_MS_BITS-1:0] bonus;
    logic [TIME_BITS:0]     sum;
    logic [COUNT_OUT_BITS-1:0] white_cnt, black_cnt;

    assign cmd      = t_cmd'(i_cmd.command);
    assign in_fire  = i_cmd.valid && i_cmd.ready;
    assign out_fire = o_res.valid && o_res.ready;

    // Times in milliseconds; both products fit their widths for every register value.
    assign base_ms   = BASE_MS_BITS'(r_base_sec) * BASE_MS_BITS'(MS_PER_S);
    assign inc_ms    = INC_MS_BITS'(r_inc_sec) * INC_MS_BITS'(MS_PER_S);
    assign base_left = TIME_BITS'(base_ms);

    // A tick only debits the running side, and only when the mode counts time.
    assign mover_left  = r_time_left[r_mover];
    assign tick_active = (r_phase == PH_RUN) && (r_mode != MODE_UNTIMED);
    assign tick_flag   = TIME_BITS'(i_cmd.elapsed_ms) >= mover_left;
    assign tick_left   = mover_left - TIME_BITS'(i_cmd.elapsed_ms);
    assign tick_warn   = (tick_left <= WARN_MS) && !r_warned[r_mover];

    // A press counts as a move only by the running side of a running clock.
    assign press_move = (r_phase == PH_RUN) && (i_cmd.side == r_mover);
    assign used_ms    = i_cmd.now_ms - r_move_start;

    // Bronstein caps the credit at the time actually used on this move.
    always_comb begin
        unique case (r_mode)
            MODE_INCREMENT: bonus = inc_ms;
            MODE_DELAY:     bonus = (used_ms < STAMP_BITS'(inc_ms)) ?
                                    INC_MS_BITS'(used_ms) : inc_ms;
            MODE_UNTIMED,
            MODE_PLAIN:     bonus = '0;
            default:        bonus = '0;
        endcase
    end

    // Remaining time never exceeds the 31-bit maximum, so a carry out means saturate.
    assign sum        = {1'b0, mover_left} + (TIME_BITS + 1)'(bonus);
    assign press_left = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (cmd)
            CMD_TICK: begin
                if (tick_active && tick_flag) begin
                    n_phase = PH_FLAG;
                end
            end
            CMD_PRESS: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_RUN;
                end
            end
            CMD_PAUSE: begin
                if (r_phase == PH_RUN) begin
                    n_phase = PH_PAUSE;
                end else if (r_phase == PH_PAUSE) begin
                    n_phase = PH_RUN;
                end
            end
            CMD_NEW_GAME: n_phase = PH_IDLE;
            default:      n_phase = r_phase;
        endcase
    end

    // Everything else the command changes, plus the alert it raises.
    always_comb begin
        n_mover      = r_mover;
        n_time_left  = r_time_left;
        n_tally      = r_tally;
        n_warned     = r_warned;
        n_move_start = r_move_start;
        n_loser      = r_loser;
        n_kind       = ALERT_NONE;
        unique case (cmd)
            CMD_TICK: begin
                if (tick_active) begin
                    if (tick_flag) begin
                        n_time_left[r_mover] = '0;
                        n_loser              = r_mover;
                        n_kind               = ALERT_FLAG;
                    end else begin
                        n_time_left[r_mover] = tick_left;
                        if (tick_warn) begin
                            n_warned[r_mover] = 1'b1;
                            n_kind            = ALERT_WARN;
                        end
                    end
                end
            end
            CMD_PRESS: begin
                if (r_phase == PH_IDLE) begin
                    // The first press starts the opponent's clock.
                    n_mover      = ~i_cmd.side;
                    n_move_start = i_cmd.now_ms;
                end else if (press_move) begin
                    n_time_left[r_mover] = press_left;
                    n_tally[r_mover]     = r_tally[r_mover] + MOVE_COUNT_BITS'(1);
                    n_mover              = ~r_mover;
                    n_move_start         = i_cmd.now_ms;
                end
            end
            CMD_PAUSE: begin
                if (r_phase == PH_PAUSE) begin
                    n_move_start = i_cmd.now_ms;
                end
            end
            CMD_NEW_GAME: begin
                n_mover        = 1'b0;
                n_time_left[0] = base_left;
                n_time_left[1] = base_left;
                n_tally[0]     = '0;
                n_tally[1]     = '0;
                n_warned       = '0;
                n_move_start   = '0;
                n_loser        = 1'b0;
            end
            default: n_kind = ALERT_NONE;
        endcase
    end

    // The counters may be wider or narrower than the 16-bit result fields.
    if (MOVE_COUNT_BITS >= COUNT_OUT_BITS) begin : g_cnt_trunc
        assign white_cnt = n_tally[0][COUNT_OUT_BITS-1:0];
        assign black_cnt = n_tally[1][COUNT_OUT_BITS-1:0];
    end else begin : g_cnt_ext
        assign white_cnt = COUNT_OUT_BITS'(n_tally[0]);
        assign black_cnt = COUNT_OUT_BITS'(n_tally[1]);
    end

    // The result shows the state after the command.
    always_comb begin
        n_result.alert            = (n_kind != ALERT_NONE);
        n_result.alert_kind       = n_kind;
        n_result.run_state        = n_phase;
        n_result.side_to_move     = n_mover;
        n_result.white_left_ms    = n_time_left[0];
        n_result.black_left_ms    = n_time_left[1];
        n_result.flagged_side     = (n_phase == PH_FLAG) ? n_loser : 1'b0;
        n_result.white_move_count = white_cnt;
        n_result.black_move_count = black_cnt;
    end

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_UNTIMED;
            r_base_sec <= BASE_RESET;
            r_inc_sec  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TIMING_MODE: r_mode     <= t_mode'(i_cfg_data[1:0]);
                CFG_BASE_SEC:    r_base_sec <= i_cfg_data[BASE_BITS-1:0];
                CFG_INC_SEC:     r_inc_sec  <= i_cfg_data[INC_BITS-1:0];
                default:         r_inc_sec  <= r_inc_sec;
            endcase
        end
    end

    // Game state advances on every accepted command transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_mover        <= 1'b0;
            r_time_left[0] <= TIME_RESET;
            r_time_left[1] <= TIME_RESET;
            r_tally[0]     <= '0;
            r_tally[1]     <= '0;
            r_warned       <= '0;
            r_move_start   <= '0;
            r_loser        <= 1'b0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_mover      <= n_mover;
            r_time_left  <= n_time_left;
            r_tally      <= n_tally;
            r_warned     <= n_warned;
            r_move_start <= n_move_start;
            r_loser      <= n_loser;
        end
    end

    // Output stage: a new result goes straight to the result register when that
    // register is free or being drained, otherwise into the skid register.
    // Input is held off only while the skid register is occupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (out_fire) begin
                    r_skid_v <= 1'b0;
                end
            end else if (in_fire) begin
                if (r_out_v && !out_fire) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_v && !out_fire) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign i_cmd.ready            = !r_skid_v;
    assign o_res.valid            = r_out_v;
    assign o_res.alert            = r_out.alert;
    assign o_res.alert_kind       = r_out.alert_kind;
    assign o_res.run_state        = r_out.run_state;
    assign o_res.side_to_move     = r_out.side_to_move;
    assign o_res.white_left_ms    = r_out.white_left_ms;
    assign o_res.black_left_ms    = r_out.black_left_ms;
    assign o_res.flagged_side     = r_out.flagged_side;
    assign o_res.white_move_count = r_out.white_move_count;
    assign o_res.black_move_count = r_out.black_move_count;

endmodule
